[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define HFQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define HFQ_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[src/hfq_pkg.sv]
// ----------------------------------------------------------------------------
// Heightfield query package
// Widths, codes and the command/status types shared by the query unit.
// ----------------------------------------------------------------------------
package hfq_pkg;

	localparam int GRID_DIM    = 64;
	localparam int CELL_W      = $clog2(GRID_DIM);
	localparam int ADDR_W      = $clog2(GRID_DIM * GRID_DIM);

	localparam int OFS_W       = 23;
	localparam int SHIFT_W     = 4;
	localparam int CFG_W       = 23;
	localparam int CFG_IDX_W   = 1;
	localparam int HEIGHT_W    = 16;
	localparam int COORD_W     = 24;
	localparam int FIELD_IDX_W = 6;

	localparam int TX_W        = COORD_W + 1;
	localparam int FRAC_W      = 14;
	localparam int SIZE_W      = FRAC_W + 1;
	localparam int DIFF_W      = HEIGHT_W + 1;
	localparam int MUL_W       = DIFF_W + SIZE_W;
	localparam int ACC_W       = MUL_W + 2;

	localparam logic [SHIFT_W-1:0] MAX_CELL_SHIFT   = 4'd14;
	localparam logic [SHIFT_W-1:0] RESET_CELL_SHIFT = 4'd8;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RECENTER   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT = 1'd1;

	typedef struct packed {
		logic                       command;
		logic [FIELD_IDX_W-1:0]     write_row;
		logic [FIELD_IDX_W-1:0]     write_col;
		logic signed [HEIGHT_W-1:0] write_height;
		logic signed [COORD_W-1:0]  query_x;
		logic signed [COORD_W-1:0]  query_z;
	} req_item_t;

	typedef struct packed {
		logic       capture;
		logic       calc;
		logic       rd_en;
		logic [1:0] rd_idx;
		logic       cap_en;
		logic [1:0] cap_idx;
		logic       init_acc;
		logic       mul_en;
		logic       mul_sel;
		logic       add_prod;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic outside;
		logic out_free;
	} dp_status_t;

endpackage

[src/hfq_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one write or query item per beat.
// ----------------------------------------------------------------------------
interface hfq_req_if import hfq_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [FIELD_IDX_W-1:0]     write_row;
	logic [FIELD_IDX_W-1:0]     write_col;
	logic signed [HEIGHT_W-1:0] write_height;
	logic signed [COORD_W-1:0]  query_x;
	logic signed [COORD_W-1:0]  query_z;

	modport source (
		output valid, command, write_row, write_col, write_height, query_x, query_z,
		input  ready
	);
	modport sink (
		input  valid, command, write_row, write_col, write_height, query_x, query_z,
		output ready
	);
endinterface

[src/hfq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one height result per beat.
// ----------------------------------------------------------------------------
interface hfq_rsp_if import hfq_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [HEIGHT_W-1:0] height_out;
	logic                       outside_grid;

	modport source (
		output valid, height_out, outside_grid,
		input  ready
	);
	modport sink (
		input  valid, height_out, outside_grid,
		output ready
	);
endinterface

[src/hfq_ctrl.sv]
// ----------------------------------------------------------------------------
// Heightfield query controller
// Sequences capture, cell decode (queries), four height reads and multiply-accumulate
// (in-grid queries) and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfq_ctrl import hfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_command,
	output logic       req_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CALC = 4'd1;
	localparam logic [3:0] S_RD0  = 4'd2;
	localparam logic [3:0] S_RD1  = 4'd3;
	localparam logic [3:0] S_RD2  = 4'd4;
	localparam logic [3:0] S_RD3  = 4'd5;
	localparam logic [3:0] S_RD4  = 4'd6;
	localparam logic [3:0] S_MUL1 = 4'd7;
	localparam logic [3:0] S_MUL2 = 4'd8;
	localparam logic [3:0] S_ADD  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = (req_command == CMD_QUERY) ? S_CALC : S_FIN;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_RD0;
			end
			S_RD0: begin
				// drop straight to the result when the point lies off the grid
				if (status.outside) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = 2'd0;
					state_d    = S_RD1;
				end
			end
			S_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_idx  = 2'd1;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd0;
				state_d     = S_RD2;
			end
			S_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_idx  = 2'd2;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd1;
				state_d     = S_RD3;
			end
			S_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_idx  = 2'd3;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd2;
				state_d     = S_RD4;
			end
			S_RD4: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd3;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.init_acc = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = 1'b0;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = 1'b1;
				cmd.add_prod = 1'b1;
				state_d      = S_ADD;
			end
			S_ADD: begin
				cmd.add_prod = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`HFQ_ASSERT(a_query_to_calc, (req_valid && req_ready && req_command == CMD_QUERY) |=> (state_q == S_CALC), "query beat not followed by cell decode")
	`HFQ_ASSERT(a_load_when_free, cmd.load_out |-> status.out_free, "result loaded over a waiting beat")
	`HFQ_ASSERT(a_heights_before_mac, cmd.init_acc |-> ($past(cmd.cap_en) && $past(cmd.cap_idx) == 2'd3), "accumulate started before all heights captured")

endmodule

[src/hfq_dp.sv]
// ----------------------------------------------------------------------------
// Heightfield query datapath
// Configuration registers, height memory, cell decode, shared multiplier,
// accumulator and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfq_dp import hfq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  req_item_t                  item,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	input  logic                       rsp_ready,
	output logic                       rsp_valid,
	output logic signed [HEIGHT_W-1:0] height_out,
	output logic                       outside_grid
);

	logic [OFS_W-1:0]           offset_q;
	logic [SHIFT_W-1:0]         cell_shift_q;
	logic [SHIFT_W-1:0]         cs;

	logic                       query_q;
	logic                       outside_q;
	logic signed [COORD_W-1:0]  qx_q;
	logic signed [COORD_W-1:0]  qz_q;

	logic signed [TX_W-1:0]     tx_c;
	logic signed [TX_W-1:0]     tz_c;
	logic [COORD_W-1:0]         gx_full;
	logic [COORD_W-1:0]         gz_full;
	logic [COORD_W-1:0]         frac_mask;
	logic [FRAC_W-1:0]          fx_c;
	logic [FRAC_W-1:0]          fz_c;
	logic [SIZE_W-1:0]          size_c;
	logic                       outside_c;

	logic [CELL_W-1:0]          gx_q;
	logic [CELL_W-1:0]          gz_q;
	logic [FRAC_W-1:0]          fx_q;
	logic [FRAC_W-1:0]          fz_q;
	logic                       upper_q;

	logic [HEIGHT_W-1:0]        mem [GRID_DIM*GRID_DIM];
	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [CELL_W-1:0]          rd_row;
	logic [CELL_W-1:0]          rd_col;
	logic [ADDR_W-1:0]          rd_addr;
	logic [HEIGHT_W-1:0]        rd_data_q;
	logic signed [HEIGHT_W-1:0] h_q [4];

	logic signed [DIFF_W-1:0]   mul_a;
	logic signed [SIZE_W-1:0]   mul_b;
	logic signed [MUL_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]    base_ext;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       acc_neg;
	logic [ACC_W-1:0]           mag;
	logic [ACC_W-1:0]           shr;
	logic [ACC_W-1:0]           res;

	logic                       out_valid_q;
	logic signed [HEIGHT_W-1:0] height_q;
	logic                       outside_out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			cell_shift_q <= RESET_CELL_SHIFT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECENTER:   offset_q     <= cfg_wdata[OFS_W-1:0];
				REG_CELL_SHIFT: cell_shift_q <= cfg_wdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cs = (cell_shift_q > MAX_CELL_SHIFT) ? MAX_CELL_SHIFT : cell_shift_q;

	// item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q   <= 1'b0;
			outside_q <= 1'b0;
		end else if (cmd.capture) begin
			query_q   <= (item.command == CMD_QUERY);
			outside_q <= 1'b0;
		end else if (cmd.calc) begin
			outside_q <= outside_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qx_q <= item.query_x;
			qz_q <= item.query_z;
		end
	end

	// cell decode: recentre, split into cell index and fraction
	assign tx_c      = TX_W'(qx_q) + $signed(TX_W'(offset_q));
	assign tz_c      = TX_W'(qz_q) + $signed(TX_W'(offset_q));
	assign gx_full   = tx_c[COORD_W-1:0] >> cs;
	assign gz_full   = tz_c[COORD_W-1:0] >> cs;
	assign frac_mask = (COORD_W'(1) << cs) - COORD_W'(1);
	assign fx_c      = FRAC_W'(tx_c[COORD_W-1:0] & frac_mask);
	assign fz_c      = FRAC_W'(tz_c[COORD_W-1:0] & frac_mask);
	assign size_c    = SIZE_W'(1) << cs;
	assign outside_c = tx_c[TX_W-1] || tz_c[TX_W-1] ||
	                   (gx_full >= COORD_W'(GRID_DIM - 1)) ||
	                   (gz_full >= COORD_W'(GRID_DIM - 1));

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			gx_q    <= gx_full[CELL_W-1:0];
			gz_q    <= gz_full[CELL_W-1:0];
			fx_q    <= fx_c;
			fz_q    <= fz_c;
			upper_q <= (SIZE_W'(fx_c) + SIZE_W'(fz_c)) > size_c;
		end
	end

	// height memory: one write and one registered read a cycle
	assign wr_en   = cmd.capture && (item.command == CMD_WRITE) &&
	                 (int'(item.write_row) < GRID_DIM) && (int'(item.write_col) < GRID_DIM);
	assign wr_addr = ADDR_W'(ADDR_W'(item.write_row) * ADDR_W'(GRID_DIM) +
	                 ADDR_W'(item.write_col));
	assign rd_row  = gx_q + CELL_W'(cmd.rd_idx[0]);
	assign rd_col  = gz_q + CELL_W'(cmd.rd_idx[1]);
	assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(GRID_DIM) + ADDR_W'(rd_col));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item.write_height;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// corner order: h00, h10, h01, h11
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			h_q[cmd.cap_idx] <= $signed(rd_data_q);
		end
	end

	// plane terms through one shared multiplier
	always_comb begin
		if (!cmd.mul_sel) begin
			mul_a = upper_q ? (DIFF_W'(h_q[3]) - DIFF_W'(h_q[2]))
			                : (DIFF_W'(h_q[1]) - DIFF_W'(h_q[0]));
			mul_b = $signed({1'b0, fx_q});
		end else begin
			mul_a = upper_q ? (DIFF_W'(h_q[3]) - DIFF_W'(h_q[1]))
			                : (DIFF_W'(h_q[2]) - DIFF_W'(h_q[0]));
			mul_b = upper_q ? ($signed({1'b0, fz_q}) - $signed(size_c))
			                : $signed({1'b0, fz_q});
		end
	end

	assign base_ext = (upper_q ? ACC_W'(h_q[2]) : ACC_W'(h_q[0])) <<< cs;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.init_acc) begin
			acc_q <= base_ext;
		end else if (cmd.add_prod) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// scale back with truncation toward zero
	assign acc_neg = acc_q[ACC_W-1];
	assign mag     = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign shr     = mag >> cs;
	assign res     = acc_neg ? (ACC_W'(0) - shr) : shr;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			height_q      <= (query_q && !outside_q) ? $signed(res[HEIGHT_W-1:0]) : '0;
			outside_out_q <= query_q && outside_q;
		end
	end

	assign status.outside  = outside_q;
	assign status.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid    = out_valid_q;
	assign height_out   = height_q;
	assign outside_grid = outside_out_q;

	`HFQ_ASSERT(a_outside_zero, (rsp_valid && outside_grid) |-> (height_out == '0), "outside beat with non-zero height")
	`HFQ_ASSERT(a_read_in_grid, cmd.rd_en |-> (query_q && !outside_q), "height read for a point off the grid")
	`HFQ_ASSERT(a_load_shows_beat, cmd.load_out |=> rsp_valid, "loaded result not presented")

endmodule

[src/heightfield_triangle_height_query_unit.sv]
// ----------------------------------------------------------------------------
// Heightfield triangle height query unit
// A write beat goes straight to its result; an off-grid query ends after the cell
// decode; an in-grid query makes four reads of the height memory, then two
// passes of the shared multiplier and two adds.
// One item at a time; the next beat is taken only after the result is loaded.
// Reset clears control, offset 0, cell shift 8; height memory is not cleared.
// ----------------------------------------------------------------------------
module heightfield_triangle_height_query_unit import hfq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	hfq_req_if.sink              req,
	hfq_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	req_item_t  item;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       ready;

	assign item.command      = req.command;
	assign item.write_row    = req.write_row;
	assign item.write_col    = req.write_col;
	assign item.write_height = req.write_height;
	assign item.query_x      = req.query_x;
	assign item.query_z      = req.query_z;
	assign req.ready         = ready;

	hfq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (ready),
		.status      (status),
		.cmd         (cmd)
	);

	hfq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.height_out   (rsp.height_out),
		.outside_grid (rsp.outside_grid)
	);

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Heightfield query unit testbench
// Loads grid heights and sends in-grid, edge and off-grid queries under six
// register settings, with random idling on both channels in the first four. Every
// result beat is checked against heights interpolated from a local copy of the grid.
// ----------------------------------------------------------------------------
module testbench;
	import hfq_pkg::*;

	localparam int IDLE_LIMIT      = 4000;
	localparam int HOLD_CYCLES     = 300;
	localparam int HOLD_AT_RESULT  = 600;
	localparam int TAIL_CYCLES     = 20;
	localparam int ITEMS_PER_PHASE = 265;
	localparam int NUM_PHASES      = 6;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       outside;
	} height_result_t;

	typedef struct {
		req_item_t item;
		bit        wait_empty;
	} queued_beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	hfq_req_if req_ch ();
	hfq_rsp_if rsp_ch ();

	heightfield_triangle_height_query_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	queued_beat_t               pending_beats[$];
	height_result_t             predicted_heights[$];
	logic signed [HEIGHT_W-1:0] height_grid [GRID_DIM*GRID_DIM];
	bit                         height_known [GRID_DIM*GRID_DIM];
	logic [OFS_W-1:0]           recenter;
	logic [SHIFT_W-1:0]         shift_reg;
	req_item_t                  on_bus;
	queued_beat_t               next_beat;
	height_result_t             expected_now;
	int send_idle_pct, recv_idle_pct;
	int mismatches, n_writes, n_inside, n_outside, n_checked, pushed;
	int idle_cycles, hold_left;
	bit hold_done;
	bit pause_queued;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_shift();
		return (shift_reg > MAX_CELL_SHIFT) ? int'(MAX_CELL_SHIFT) : int'(shift_reg);
	endfunction

	// cell index along one axis, -1 when the recentred coordinate is off the grid
	function automatic void locate(input logic signed [COORD_W-1:0] coord,
		output int cell_idx, output longint frac);
		longint t;
		int     cs;
		cs   = eff_shift();
		t    = longint'(coord) + longint'(recenter);
		frac = t & ((longint'(1) << cs) - 1);
		if (t < 0 || (t >>> cs) >= GRID_DIM - 1)
			cell_idx = -1;
		else
			cell_idx = int'(t >>> cs);
	endfunction

	function automatic height_result_t interpolate_height(req_item_t it);
		height_result_t r;
		int     gx, gz, cs;
		longint fx, fz, size, h00, h10, h01, h11, num, mag;
		r = '0;
		if (it.command == CMD_WRITE) begin
			height_grid[{it.write_row, it.write_col}] = it.write_height;
			n_writes++;
			return r;
		end
		locate(it.query_x, gx, fx);
		locate(it.query_z, gz, fz);
		if (gx < 0 || gz < 0) begin
			r.outside = 1'b1;
			n_outside++;
			return r;
		end
		cs   = eff_shift();
		size = longint'(1) << cs;
		h00  = height_grid[gx*GRID_DIM + gz];
		h10  = height_grid[(gx+1)*GRID_DIM + gz];
		h01  = height_grid[gx*GRID_DIM + gz + 1];
		h11  = height_grid[(gx+1)*GRID_DIM + gz + 1];
		// lower triangle includes the diagonal itself
		if (fx + fz <= size)
			num = h00*size + (h10 - h00)*fx + (h01 - h00)*fz;
		else
			num = h01*size + (h11 - h01)*fx + (h11 - h10)*(fz - size);
		mag = (num < 0) ? -num : num;
		mag = mag >> cs;
		num = (num < 0) ? -mag : mag;
		r.height = num[HEIGHT_W-1:0];
		n_inside++;
		return r;
	endfunction

	function automatic logic signed [HEIGHT_W-1:0] pick_height();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return r[HEIGHT_W-1:0];
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] coord_in_cell(int cell_idx, longint frac);
		longint v;
		v = (longint'(cell_idx) << eff_shift()) + frac - longint'(recenter);
		return v[COORD_W-1:0];
	endfunction

	function automatic void push_write(int row, int col, logic signed [HEIGHT_W-1:0] h,
		bit wait_empty);
		queued_beat_t b;
		b.item.command      = CMD_WRITE;
		b.item.write_row    = row[FIELD_IDX_W-1:0];
		b.item.write_col    = col[FIELD_IDX_W-1:0];
		b.item.write_height = h;
		b.item.query_x      = COORD_W'($urandom);
		b.item.query_z      = COORD_W'($urandom);
		b.wait_empty        = wait_empty;
		height_known[row*GRID_DIM + col] = 1'b1;
		pending_beats.insert(pending_beats.size(), b);
		pushed++;
	endfunction

	// load any corner not yet written, so no query ever reads an unknown height
	function automatic void push_query(logic signed [COORD_W-1:0] qx,
		logic signed [COORD_W-1:0] qz, bit wait_empty);
		queued_beat_t b;
		int     gx, gz;
		longint f;
		locate(qx, gx, f);
		locate(qz, gz, f);
		if (gx >= 0 && gz >= 0)
			for (int dx = 0; dx < 2; dx++)
				for (int dz = 0; dz < 2; dz++)
					if (!height_known[(gx+dx)*GRID_DIM + gz + dz])
						push_write(gx + dx, gz + dz, pick_height(), 1'b0);
		b.item.command      = CMD_QUERY;
		b.item.write_row    = FIELD_IDX_W'($urandom);
		b.item.write_col    = FIELD_IDX_W'($urandom);
		b.item.write_height = HEIGHT_W'($urandom);
		b.item.query_x      = qx;
		b.item.query_z      = qz;
		b.wait_empty        = wait_empty;
		pending_beats.insert(pending_beats.size(), b);
		pushed++;
	endfunction

	function automatic void random_beat(bit wait_empty);
		int     kind, gx, gz;
		longint size, fx, fz;
		size = longint'(1) << eff_shift();
		kind = $urandom_range(99);
		gx   = ($urandom_range(3) == 0) ? $urandom_range(GRID_DIM - 2) : $urandom_range(5);
		gz   = ($urandom_range(3) == 0) ? $urandom_range(GRID_DIM - 2) : $urandom_range(5);
		if ($urandom_range(15) == 0)
			gx = GRID_DIM - 2;
		if ($urandom_range(15) == 0)
			gz = GRID_DIM - 2;
		fx = longint'($urandom) & (size - 1);
		fz = longint'($urandom) & (size - 1);
		case ($urandom_range(5))
			0: begin
				fx = 0;
				fz = 0;
			end
			1: fz = (fx == 0) ? 0 : size - fx;
			2: begin
				fx = size - 1;
				fz = size - 1;
			end
			default: ;
		endcase
		if (kind < 70)
			push_query(coord_in_cell(gx, fx), coord_in_cell(gz, fz), wait_empty);
		else if (kind < 80)
			case ($urandom_range(2))
				0: push_query(coord_in_cell(GRID_DIM - 1, fx), coord_in_cell(gz, fz), wait_empty);
				1: push_query(coord_in_cell(gx, fx), coord_in_cell(GRID_DIM - 1, fz), wait_empty);
				default: push_query(coord_in_cell(0, -1 - fx), coord_in_cell(gz, fz), wait_empty);
			endcase
		else if (kind < 88)
			push_query(COORD_W'($urandom), COORD_W'($urandom), wait_empty);
		else
			push_write($urandom_range(GRID_DIM - 1), $urandom_range(GRID_DIM - 1),
				pick_height(), wait_empty);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_RECENTER)
			recenter = data[OFS_W-1:0];
		else
			shift_reg = data[SHIFT_W-1:0];
	endtask

	function automatic void directed_beats();
		push_write(0, 0, 16'sh8000, 1'b0);
		push_write(1, 0, 16'sh7fff, 1'b0);
		push_write(0, 1, 16'sh7fff, 1'b0);
		push_write(1, 1, 16'sh8000, 1'b0);
		push_write(62, 62, 16'sd100, 1'b0);
		push_write(63, 62, -16'sd7, 1'b0);
		push_write(62, 63, 16'sh7fff, 1'b0);
		push_write(63, 63, 16'sh8000, 1'b0);
		// reset setting: offset 0, one cell per 256 units
		push_query(24'sd0, 24'sd0, 1'b0);
		push_query(24'sd255, 24'sd1, 1'b0);
		push_query(24'sd128, 24'sd129, 1'b0);
		push_query(24'sd255, 24'sd255, 1'b0);
		push_query(24'sd1, 24'sd0, 1'b0);
		push_query(24'sd16127, 24'sd15873, 1'b0);
		push_query(24'sd15875, 24'sd16122, 1'b0);
		push_query(24'sd16128, 24'sd0, 1'b0);
		push_query(24'sd0, 24'sd16128, 1'b0);
		push_query(-24'sd1, 24'sd0, 1'b0);
		push_query(24'sh800000, 24'sh7fffff, 1'b0);
		push_query(24'sh7fffff, 24'sh800000, 1'b0);
	endfunction

	// request driver: hold the beat until taken, then offer the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predicted_heights.insert(predicted_heights.size(), interpolate_height(on_bus));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& !(pending_beats[0].wait_empty && predicted_heights.size() != 0)) begin
					next_beat = pending_beats.pop_front();
					on_bus    = next_beat.item;
					req_ch.valid        <= 1'b1;
					req_ch.command      <= on_bus.command;
					req_ch.write_row    <= on_bus.write_row;
					req_ch.write_col    <= on_bus.write_col;
					req_ch.write_height <= on_bus.write_height;
					req_ch.query_x      <= on_bus.query_x;
					req_ch.query_z      <= on_bus.query_z;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_heights.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat: height_out %0d outside_grid %0b",
						$time, rsp_ch.height_out, rsp_ch.outside_grid);
				end else begin
					expected_now = predicted_heights.pop_front();
					n_checked++;
					if (expected_now.height !== rsp_ch.height_out) begin
						mismatches++;
						$display("%0t: height_out expected %0d actual %0d",
							$time, expected_now.height, rsp_ch.height_out);
					end
					if (expected_now.outside !== rsp_ch.outside_grid) begin
						mismatches++;
						$display("%0t: outside_grid expected %0b actual %0b",
							$time, expected_now.outside, rsp_ch.outside_grid);
					end
				end
			end
			if (!hold_done && n_checked == HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("heightfield_triangle_height_query_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_WRITE;
		req_ch.write_row    = '0;
		req_ch.write_col    = '0;
		req_ch.write_height = '0;
		req_ch.query_x      = '0;
		req_ch.query_z      = '0;
		rsp_ch.ready        = 1'b0;
		recenter            = '0;
		shift_reg           = RESET_CELL_SHIFT;
		mismatches = 0; n_writes = 0; n_inside = 0; n_outside = 0; n_checked = 0;
		idle_cycles = 0; hold_left = 0; hold_done = 1'b0; pause_queued = 1'b0;
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase < 2) begin
				send_idle_pct = 26;
				recv_idle_pct = 51;
			end else if (phase < 4) begin
				send_idle_pct = 51;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				1: begin
					write_reg(REG_RECENTER, 23'h7fffff);
					write_reg(REG_CELL_SHIFT, 23'd0);
				end
				2: begin
					write_reg(REG_RECENTER, 23'd0);
					write_reg(REG_CELL_SHIFT, CFG_W'(MAX_CELL_SHIFT));
				end
				3: begin
					// cell shift of 15 saturates; upper data bits are don't-care
					write_reg(REG_RECENTER, CFG_W'($urandom));
					write_reg(REG_CELL_SHIFT, CFG_W'($urandom | 32'hf));
				end
				4: begin
					write_reg(REG_RECENTER, 23'd1280);
					write_reg(REG_CELL_SHIFT, 23'd4);
				end
				5: begin
					write_reg(REG_RECENTER, CFG_W'($urandom));
					write_reg(REG_CELL_SHIFT, CFG_W'(($urandom & ~32'hf) | $urandom_range(14)));
				end
				default: ;
			endcase
			pushed = 0;
			if (phase == 0)
				directed_beats();
			while (pushed < ITEMS_PER_PHASE) begin
				// once mid-run, hold the sender until every result is back
				if (phase == 3 && pushed >= 100 && !pause_queued) begin
					pause_queued = 1'b1;
					random_beat(1'b1);
				end else begin
					random_beat(1'b0);
				end
			end
			// drain before the next register setting
			while (pending_beats.size() != 0 || req_ch.valid || predicted_heights.size() != 0)
				@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d height writes, %0d in-grid and %0d off-grid queries",
			n_writes, n_inside, n_outside);
		$display("%0d result beats checked over %0d register settings, %0d mismatches",
			n_checked, NUM_PHASES, mismatches);
		if (mismatches == 0 && predicted_heights.size() == 0)
			$display("heightfield_triangle_height_query_unit verification clean");
		else
			$display("heightfield_triangle_height_query_unit verification failed");
		$finish;
	end

endmodule
